>>> sv/hrsp_pkg.sv
// shared types, constants and helper functions for the http request stream parser
// no dependencies
package hrsp_pkg;

   localparam int LenWidthDefault = 48;
   localparam int OutLenWidth     = 48;

   // phase codes
   localparam logic [2:0] PH_METHOD   = 3'd0;
   localparam logic [2:0] PH_PATH     = 3'd1;
   localparam logic [2:0] PH_ARGS     = 3'd2;
   localparam logic [2:0] PH_SKIPLINE = 3'd3;
   localparam logic [2:0] PH_HEADERS  = 3'd4;
   localparam logic [2:0] PH_BODYLEN  = 3'd5;
   localparam logic [2:0] PH_CHUNKED  = 3'd6;

   // header line sub states
   localparam logic [3:0] HS_LS     = 4'd0;
   localparam logic [3:0] HS_LSCR   = 4'd1;
   localparam logic [3:0] HS_NAME   = 4'd2;
   localparam logic [3:0] HS_LEADSP = 4'd3;
   localparam logic [3:0] HS_VALUE  = 4'd4;
   localparam logic [3:0] HS_VALCR  = 4'd5;

   // chunk sub states
   localparam logic [3:0] CS_SIZE   = 4'd0;
   localparam logic [3:0] CS_SIZECR = 4'd1;
   localparam logic [3:0] CS_DATA   = 4'd2;
   localparam logic [3:0] CS_SKIP1  = 4'd3;
   localparam logic [3:0] CS_SKIP2  = 4'd4;

   // query sub states
   localparam logic [3:0] AS_NAME0 = 4'd0;
   localparam logic [3:0] AS_NAME  = 4'd1;
   localparam logic [3:0] AS_VALUE = 4'd2;

   // header value kinds
   localparam logic [1:0] VK_NONE   = 2'd0;
   localparam logic [1:0] VK_LENGTH = 2'd1;
   localparam logic [1:0] VK_TE     = 2'd2;
   localparam logic [1:0] VK_CONN   = 2'd3;

   // region codes
   localparam logic [2:0] RG_DELIM  = 3'd0;
   localparam logic [2:0] RG_METHOD = 3'd1;
   localparam logic [2:0] RG_PATH   = 3'd2;
   localparam logic [2:0] RG_ANAME  = 3'd3;
   localparam logic [2:0] RG_AVALUE = 3'd4;
   localparam logic [2:0] RG_HNAME  = 3'd5;
   localparam logic [2:0] RG_HVALUE = 3'd6;
   localparam logic [2:0] RG_BODY   = 3'd7;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_QM    = 8'h3f;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_SEMI  = 8'h3b;

   localparam logic [4:0] LEN_CL = 5'd14;
   localparam logic [4:0] LEN_TE = 5'd17;
   localparam logic [4:0] LEN_CN = 5'd10;
   localparam logic [2:0] LEN_CHUNKED = 3'd7;
   localparam logic [2:0] LEN_CLOSE   = 3'd5;

   // keyword tables, first letter at index zero
   localparam logic [0:13][7:0] HDR_CL       = "content-length";
   localparam logic [0:16][7:0] HDR_TE       = "transfer-encoding";
   localparam logic [0:9][7:0]  HDR_CN       = "connection";
   localparam logic [0:6][7:0]  WORD_CHUNKED = "chunked";
   localparam logic [0:4][7:0]  WORD_CLOSE   = "close";

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] region;
      logic       token_end;
      logic       segment_end;
      logic       request_done;
      logic       malformed;
      logic       truncated;
      logic [OutLenWidth-1:0] parsed_length;
      logic       chunked_body;
      logic       client_close;
   } rsp_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
   endfunction

   // real hex value; non hex bytes give their low nibble
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] l;
      l = to_lower(c);
      if (l >= 8'h61 && l <= 8'h66) return 4'(l - 8'h57);
      return c[3:0];
   endfunction

   function automatic logic [7:0] hdr_char(input logic [1:0] k, input logic [4:0] p);
      logic [7:0] c;
      c = 8'h00;
      if (k == 2'd0) begin
         if (p < LEN_CL) c = HDR_CL[p[3:0]];
      end else if (k == 2'd1) begin
         if (p < LEN_TE) c = HDR_TE[p];
      end else begin
         if (p < LEN_CN) c = HDR_CN[p[3:0]];
      end
      return c;
   endfunction

   function automatic logic [7:0] word_char(input logic is_te, input logic [2:0] p);
      logic [7:0] c;
      c = 8'h00;
      if (is_te) begin
         if (p < LEN_CHUNKED) c = WORD_CHUNKED[p];
      end else begin
         if (p < LEN_CLOSE) c = WORD_CLOSE[p];
      end
      return c;
   endfunction

endpackage

>>> sv/hrsp_if.sv
// valid/ready channel with a generic payload
// depends on nothing
interface hrsp_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/hrsp_core.sv
// per-byte parser state and next-state logic, one byte per cycle while step is high
// depends on hrsp_pkg
module hrsp_core #(
   parameter int LEN_WIDTH = hrsp_pkg::LenWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            data_byte,
   input  logic                  end_of_stream,
   output hrsp_pkg::rsp_type     rsp
);
   import hrsp_pkg::*;

   localparam logic [LEN_WIDTH-1:0] LenMax = '1;

   logic [2:0] phase_ff, phase_in;
   logic [3:0] sub_ff, sub_in;
   logic [4:0] npos_ff, npos_in;
   logic [2:0] cand_ff, cand_in;
   logic [1:0] vk_ff, vk_in;
   logic [2:0] ppos_ff, ppos_in;
   logic [LEN_WIDTH-1:0] len_ff, len_in, rem_ff, rem_in;
   logic chk_ff, chk_in, cls_ff, cls_in, ext_ff, ext_in;

   logic [7:0] b, lc;
   logic [2:0] region;
   logic tok, seg, done, mal, trunc;
   logic [3:0] dig, hx;
   logic [LEN_WIDTH+3:0] len_x10, rem_x16;
   logic [LEN_WIDTH-1:0] rem_dec;

   // multiply-by-ten and shift-by-four, four bits wider for saturation, and a decrement that stops at zero
   always_comb begin
      dig     = 4'(data_byte - 8'h30);
      hx      = hex_value(data_byte);
      len_x10 = ({4'd0, len_ff} << 3) + ({4'd0, len_ff} << 1) + (LEN_WIDTH+4)'(dig);
      rem_x16 = ({4'd0, rem_ff} << 4) + (LEN_WIDTH+4)'(hx);
      rem_dec = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;
   end

   // next-state logic
   always_comb begin
      phase_in = phase_ff; sub_in = sub_ff; npos_in = npos_ff; cand_in = cand_ff;
      vk_in = vk_ff; ppos_in = ppos_ff; len_in = len_ff; rem_in = rem_ff;
      chk_in = chk_ff; cls_in = cls_ff; ext_in = ext_ff;
      b = data_byte; lc = to_lower(data_byte);
      region = RG_DELIM; tok = 1'b0; seg = 1'b0; done = 1'b0; mal = 1'b0; trunc = 1'b0;
      if (end_of_stream) begin
         b = 8'h00;
         if (!(phase_ff == PH_METHOD && sub_ff == 4'd0)) begin
            done  = 1'b1;
            trunc = !(phase_ff == PH_CHUNKED && (sub_ff == CS_SKIP1 || sub_ff == CS_SKIP2));
         end
      end else begin
         unique case (phase_ff)
            PH_PATH: begin
               if (b == CH_QM) begin
                  tok = 1'b1; phase_in = PH_ARGS; sub_in = AS_NAME0;
               end else if (b == CH_SP || b == CH_CR) begin
                  tok = 1'b1; phase_in = PH_SKIPLINE;
               end else region = RG_PATH;
            end
            PH_ARGS: begin
               if (sub_ff == AS_VALUE) begin
                  if (b == CH_AMP) begin
                     tok = 1'b1; sub_in = AS_NAME0;
                  end else if (b == CH_SP || b == CH_CR) begin
                     tok = 1'b1; phase_in = PH_SKIPLINE;
                  end else region = RG_AVALUE;
               end else begin
                  if (b == CH_EQ) begin
                     tok = 1'b1; sub_in = AS_VALUE;
                  end else if (b == CH_AMP) begin
                     tok = 1'b1; sub_in = AS_NAME0;
                  end else if (b == CH_SP || b == CH_CR) begin
                     tok = (sub_ff == AS_NAME); phase_in = PH_SKIPLINE;
                  end else begin
                     region = RG_ANAME; sub_in = AS_NAME;
                  end
               end
            end
            PH_SKIPLINE: begin
               if (b == CH_LF) begin
                  phase_in = PH_HEADERS; sub_in = HS_LS; npos_in = '0; cand_in = 3'b111;
               end
            end
            PH_HEADERS: begin
               if (sub_ff == HS_LSCR) begin
                  if (b == CH_LF) begin
                     if (chk_ff) begin
                        phase_in = PH_CHUNKED; sub_in = CS_SIZE; rem_in = '0; ext_in = 1'b0;
                     end else if (len_ff == '0) done = 1'b1;
                     else begin
                        rem_in = len_ff; phase_in = PH_BODYLEN; sub_in = 4'd0;
                     end
                  end else begin
                     mal = 1'b1; done = 1'b1;
                  end
               end else if (sub_ff == HS_VALCR) begin
                  if (b == CH_LF) begin
                     sub_in = HS_LS; npos_in = '0; cand_in = 3'b111;
                  end else begin
                     mal = 1'b1; done = 1'b1;
                  end
               end else if (sub_ff == HS_LEADSP || sub_ff == HS_VALUE) begin
                  if (!(sub_ff == HS_LEADSP && b == CH_SP)) begin
                     sub_in = HS_VALUE;
                     if (b == CH_CR) begin
                        tok = 1'b1; vk_in = VK_NONE; sub_in = HS_VALCR;
                     end else begin
                        region = RG_HVALUE;
                        if (vk_ff == VK_LENGTH) begin
                           if (b >= 8'h30 && b <= 8'h39)
                              len_in = (len_x10[LEN_WIDTH+3:LEN_WIDTH] != '0)
                                 ? LenMax : len_x10[LEN_WIDTH-1:0];
                        end else if (vk_ff != VK_NONE) begin
                           if (ppos_ff < ((vk_ff == VK_TE) ? LEN_CHUNKED : LEN_CLOSE) &&
                               lc == word_char(vk_ff == VK_TE, ppos_ff)) begin
                              ppos_in = ppos_ff + 3'd1;
                              if (ppos_in == ((vk_ff == VK_TE) ? LEN_CHUNKED : LEN_CLOSE)) begin
                                 if (vk_ff == VK_TE) chk_in = 1'b1;
                                 else cls_in = 1'b1;
                                 vk_in = VK_NONE;
                              end
                           end else vk_in = VK_NONE;
                        end
                     end
                  end
               end else begin
                  if (b == CH_CR) begin
                     if (sub_ff == HS_LS) sub_in = HS_LSCR;
                     else begin
                        mal = 1'b1; done = 1'b1;
                     end
                  end else if (b == CH_COLON) begin
                     tok = 1'b1;
                     vk_in = VK_NONE;
                     if (cand_ff[0] && npos_ff == LEN_CL) vk_in = VK_LENGTH;
                     if (cand_ff[1] && npos_ff == LEN_TE) vk_in = VK_TE;
                     if (cand_ff[2] && npos_ff == LEN_CN) vk_in = VK_CONN;
                     if (vk_in == VK_LENGTH) len_in = '0;
                     ppos_in = '0;
                     sub_in = HS_LEADSP;
                  end else begin
                     region = RG_HNAME; sub_in = HS_NAME;
                     if (npos_ff >= LEN_CL || lc != hdr_char(2'd0, npos_ff)) cand_in[0] = 1'b0;
                     if (npos_ff >= LEN_TE || lc != hdr_char(2'd1, npos_ff)) cand_in[1] = 1'b0;
                     if (npos_ff >= LEN_CN || lc != hdr_char(2'd2, npos_ff)) cand_in[2] = 1'b0;
                     if (npos_ff != 5'd31) npos_in = npos_ff + 5'd1;
                  end
               end
            end
            PH_BODYLEN: begin
               region = RG_BODY; rem_in = rem_dec;
               if (rem_dec == '0) begin
                  seg = 1'b1; done = 1'b1;
               end
            end
            PH_CHUNKED: begin
               unique case (sub_ff)
                  CS_DATA: begin
                     region = RG_BODY; rem_in = rem_dec;
                     if (rem_dec == '0) begin
                        seg = 1'b1; sub_in = CS_SKIP1;
                     end
                  end
                  CS_SKIP1: sub_in = CS_SKIP2;
                  CS_SKIP2: begin
                     sub_in = CS_SIZE; rem_in = '0; ext_in = 1'b0;
                  end
                  CS_SIZECR: begin
                     if (b == CH_LF) begin
                        if (rem_ff == '0) done = 1'b1;
                        else sub_in = CS_DATA;
                     end else begin
                        ext_in = 1'b1;
                        if (b != CH_CR) sub_in = CS_SIZE;
                     end
                  end
                  default: begin
                     if (b == CH_CR) sub_in = CS_SIZECR;
                     else if (b == CH_SEMI) ext_in = 1'b1;
                     else if (!ext_ff)
                        rem_in = (rem_x16[LEN_WIDTH+3:LEN_WIDTH] != '0)
                           ? LenMax : rem_x16[LEN_WIDTH-1:0];
                  end
               endcase
            end
            default: begin
               phase_in = PH_METHOD; sub_in = 4'd1;
               if (b == CH_SP) begin
                  tok = 1'b1; phase_in = PH_PATH;
               end else region = RG_METHOD;
            end
         endcase
      end
      rsp.out_byte = b; rsp.region = region; rsp.token_end = tok; rsp.segment_end = seg;
      rsp.request_done = done; rsp.malformed = mal; rsp.truncated = trunc;
      rsp.parsed_length = OutLenWidth'({{(OutLenWidth > LEN_WIDTH ? OutLenWidth - LEN_WIDTH : 1){1'b0}}, len_in});
      rsp.chunked_body = chk_in; rsp.client_close = cls_in;
   end

   // state registers, cleared at reset and at request end
   always_ff @(posedge clock) begin
      if (reset || (step && done)) begin
         phase_ff <= PH_METHOD; sub_ff <= '0; npos_ff <= '0; cand_ff <= 3'b111;
         vk_ff <= VK_NONE; ppos_ff <= '0; len_ff <= '0; rem_ff <= '0;
         chk_ff <= 1'b0; cls_ff <= 1'b0; ext_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; sub_ff <= sub_in; npos_ff <= npos_in; cand_ff <= cand_in;
         vk_ff <= vk_in; ppos_ff <= ppos_in; len_ff <= len_in; rem_ff <= rem_in;
         chk_ff <= chk_in; cls_ff <= cls_in; ext_ff <= ext_in;
      end
   end

`ifndef SYNTHESIS
   a_trunc_done: assert property (@(posedge clock) disable iff (reset)
      rsp.truncated |-> rsp.request_done) else $error("truncated without done");
   a_mal_done: assert property (@(posedge clock) disable iff (reset)
      rsp.malformed |-> rsp.request_done) else $error("malformed without done");
   a_done_clear: assert property (@(posedge clock) disable iff (reset)
      (step && rsp.request_done) |=> (phase_ff == PH_METHOD && sub_ff == 4'd0))
      else $error("state not cleared after done");
   a_seg_body: assert property (@(posedge clock) disable iff (reset)
      rsp.segment_end |-> rsp.region == RG_BODY) else $error("segment end outside body");
`endif
endmodule

>>> sv/http_request_stream_parser_top.sv
// top level: input register, parser core, output register
// depends on hrsp_pkg, hrsp_if, hrsp_core
// Tags an HTTP/1.1 request one byte per cycle while rsp is not stalled. A byte
// accepted on req is registered, parsed in a single pass of logic and its
// tagged result registered for rsp. The sustained rate is one byte per clock
// while rsp is ready, set by the state update of the parser core once per byte.
// Both stages advance whenever the result stage is empty or being drained.
module http_request_stream_parser_top #(
   parameter int LEN_WIDTH = hrsp_pkg::LenWidthDefault
) (
   input logic clock,
   input logic reset,
   hrsp_if.sink   req_chan,
   hrsp_if.source rsp_chan
);
   import hrsp_pkg::*;

   logic       in_vld_ff, out_vld_ff;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;
   rsp_type    core_rsp, out_ff;
   logic       adv_out, adv_in;

   // pipeline advance
   assign adv_out = !out_vld_ff || rsp_chan.ready;
   assign adv_in  = !in_vld_ff || adv_out;
   assign req_chan.ready = adv_in;
   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.payload = out_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else if (adv_in) in_vld_ff <= req_chan.valid;
      if (adv_in && req_chan.valid) begin
         in_byte_ff <= req_chan.payload[8:1];
         in_eos_ff  <= req_chan.payload[0];
      end
   end

   hrsp_core #(.LEN_WIDTH(LEN_WIDTH)) u_core (
      .clock(clock), .reset(reset), .step(in_vld_ff && adv_out),
      .data_byte(in_byte_ff), .end_of_stream(in_eos_ff), .rsp(core_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv_out) out_vld_ff <= in_vld_ff;
      if (adv_out && in_vld_ff) out_ff <= core_rsp;
   end

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_chan.ready) |=> out_vld_ff) else $error("result dropped");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !adv_out) |=> in_vld_ff) else $error("input item lost");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (!in_vld_ff) |-> req_chan.ready) else $error("not ready while empty");
`endif
endmodule
